// ===== rtl/core/sbpr_pkg.sv =====
// Package for the six-button pad reader.
// Holds the per-port state record, button bit positions and poll constants.
// No dependencies.
`default_nettype none

package sbpr_pkg;

    // Bit positions inside the 13-bit button word.
    localparam int unsigned BIT_UP    = 0;
    localparam int unsigned BIT_DOWN  = 1;
    localparam int unsigned BIT_LEFT  = 2;
    localparam int unsigned BIT_RIGHT = 3;
    localparam int unsigned BIT_A     = 4;
    localparam int unsigned BIT_B     = 5;
    localparam int unsigned BIT_C     = 6;
    localparam int unsigned BIT_START = 7;
    localparam int unsigned BIT_X     = 8;
    localparam int unsigned BIT_Y     = 9;
    localparam int unsigned BIT_Z     = 10;
    localparam int unsigned BIT_MODE  = 11;
    localparam int unsigned BIT_HOME  = 12;

    localparam int unsigned WORD_W = 13;
    localparam int unsigned SKIP_W = 2;

    // Number of polls skipped after a six-button read.
    localparam logic [SKIP_W-1:0] SKIP_POLLS = 2'd2;

    typedef logic [WORD_W-1:0] t_word;

    // State kept for one port in the state memory.
    typedef struct packed {
        logic              sel;
        logic              conn;
        logic              six;
        logic [SKIP_W-1:0] skip;
        t_word             word;
    } t_port_state;

endpackage

`default_nettype wire

// ===== rtl/core/sbpr_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Used for the per-port state store; depends on nothing.
`default_nettype none

module sbpr_ram #(
    parameter int WIDTH  = 18,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/six_button_pad_reader.sv =====
// Six-button pad reader: per-port poll decoder built around a state memory.
// A poll passes the stage 1 registers, then the output register, to o_valid.
// Throughput: one poll per cycle unless stalled; the state memory's read-modify-write
// sets the pace, with a write-forwarding register for back-to-back polls.
// Reset: per-port valid bits clear at once, so every port reads as all zero.
// Depends on sbpr_pkg and sbpr_ram.
`default_nettype none

module six_button_pad_reader
    import sbpr_pkg::*;
#(
    parameter int NUM_PORTS = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Poll sample channel.
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_port,
    input  wire logic        i_pin_up_level,
    input  wire logic        i_pin_down_level,
    input  wire logic        i_pin_left_level,
    input  wire logic        i_pin_right_level,
    input  wire logic        i_pin_tl_level,
    input  wire logic        i_pin_tr_level,
    // Result channel.
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_port_out,
    output logic [WORD_W-1:0] o_buttons,
    output logic             o_pad_connected,
    output logic             o_next_select
);

    localparam int ADDR_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int ST_W   = $bits(t_port_state);

    typedef logic [ADDR_W-1:0] t_addr;

    // Handshake and stage control.
    logic        in_acc;
    logic        s1_adv;
    logic        in_range;
    t_addr       in_addr;

    // Stage 1 registers: the poll waiting on its memory read.
    logic        r_s1_vld;
    logic        r_s1_port;
    logic        r_s1_range;
    t_addr       r_s1_addr;
    logic        r_s1_ent_vld;
    logic [5:0]  r_s1_pins;

    // Per-entry valid bits and the write-forwarding register.
    logic        r_ent_vld [NUM_PORTS];
    logic        r_byp_vld;
    t_addr       r_byp_addr;
    t_port_state r_byp_data;

    // Memory read data and decode signals.
    logic [ST_W-1:0] rd_data;
    t_port_state cur;
    t_port_state n_st;
    logic        up, down, left, right, tl, tr;

    // Output register.
    logic        r_out_vld;
    logic        r_out_port;
    t_word       r_out_buttons;
    logic        r_out_conn;
    logic        r_out_sel;

    assign in_addr  = t_addr'(i_port);
    assign in_range = (32'(i_port) < NUM_PORTS);

    // Stage 1 moves on when the output register is free or being emptied.
    assign s1_adv  = !r_out_vld || !i_stall;
    assign o_stall = r_s1_vld && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    sbpr_ram #(
        .WIDTH  (ST_W),
        .DEPTH  (NUM_PORTS),
        .ADDR_W (ADDR_W)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld && s1_adv && r_s1_range),
        .i_waddr (r_s1_addr),
        .i_wdata (n_st),
        .i_re    (in_acc),
        .i_raddr (in_addr),
        .o_rdata (rd_data)
    );

    // Stage 1 capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_port    <= i_port;
            r_s1_range   <= in_range;
            r_s1_addr    <= in_addr;
            r_s1_ent_vld <= in_range && r_ent_vld[in_addr];
            r_s1_pins    <= {i_pin_tr_level, i_pin_tl_level, i_pin_right_level,
                             i_pin_left_level, i_pin_down_level, i_pin_up_level};
        end
    end

    // Current state: the last write to this port wins, then the memory,
    // and an entry never written reads as the reset value.
    always_comb begin
        if (r_byp_vld && (r_byp_addr == r_s1_addr)) begin
            cur = r_byp_data;
        end else if (r_s1_ent_vld) begin
            cur = t_port_state'(rd_data);
        end else begin
            cur = '0;
        end
    end

    // Pad lines are active low.
    assign up    = !r_s1_pins[0];
    assign down  = !r_s1_pins[1];
    assign left  = !r_s1_pins[2];
    assign right = !r_s1_pins[3];
    assign tl    = !r_s1_pins[4];
    assign tr    = !r_s1_pins[5];

    // Poll decode: the next state of the polled port.
    always_comb begin
        n_st = cur;
        if (cur.skip != '0) begin
            // Skipped poll after a six-button read; Home comes in the first.
            if (cur.skip == SKIP_POLLS) begin
                n_st.word[BIT_HOME] = up;
            end
            n_st.skip = cur.skip - 1'b1;
        end else if (cur.sel) begin
            if (cur.conn) begin
                if (cur.six) begin
                    n_st.word[BIT_Z]    = up;
                    n_st.word[BIT_Y]    = down;
                    n_st.word[BIT_X]    = left;
                    n_st.word[BIT_MODE] = right;
                    n_st.six            = 1'b0;
                    n_st.skip           = SKIP_POLLS;
                end else begin
                    n_st.word[BIT_UP]    = up;
                    n_st.word[BIT_DOWN]  = down;
                    n_st.word[BIT_LEFT]  = left;
                    n_st.word[BIT_RIGHT] = right;
                    n_st.word[BIT_B]     = tl;
                    n_st.word[BIT_C]     = tr;
                end
            end else begin
                // No pad detected: rebuild a plain two-button state.
                n_st.word            = '0;
                n_st.word[BIT_UP]    = up;
                n_st.word[BIT_DOWN]  = down;
                n_st.word[BIT_LEFT]  = left;
                n_st.word[BIT_RIGHT] = right;
                n_st.word[BIT_A]     = tl;
                n_st.word[BIT_B]     = tr;
            end
        end else begin
            // Select low: detection, and A and Start on a three-button read.
            n_st.conn = left && right;
            n_st.six  = up && down;
            if (left && right && !(up && down)) begin
                n_st.word[BIT_A]     = tl;
                n_st.word[BIT_START] = tr;
            end
        end
        n_st.sel = !cur.sel;
    end

    // Valid bits and forwarding register follow every state write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PORTS; k++) begin
                r_ent_vld[k] <= 1'b0;
            end
            r_byp_vld <= 1'b0;
        end else if (r_s1_vld && s1_adv && r_s1_range) begin
            r_ent_vld[r_s1_addr] <= 1'b1;
            r_byp_vld            <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && s1_adv && r_s1_range) begin
            r_byp_addr <= r_s1_addr;
            r_byp_data <= n_st;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_out_port <= r_s1_port;
            if (r_s1_range) begin
                r_out_buttons <= n_st.word;
                r_out_conn    <= n_st.conn;
                r_out_sel     <= n_st.sel;
            end else begin
                r_out_buttons <= '0;
                r_out_conn    <= 1'b0;
                r_out_sel     <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_vld;
    assign o_port_out      = r_out_port;
    assign o_buttons       = r_out_buttons;
    assign o_pad_connected = r_out_conn;
    assign o_next_select   = r_out_sel;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for six_button_pad_reader: drives poll items and checks every result item
// against a behavioral predictor of the per-port pad decoder or a typed-in result.
// Depends on sbpr_pkg and the six_button_pad_reader RTL.
`timescale 1ns / 1ps

module testbench
    import sbpr_pkg::*;
();

    localparam int NUM_PORTS      = 2;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 20;
    localparam int MAX_REPORTS    = 10;

    // One poll item: port, then the six pin levels (0 means pressed).
    typedef struct packed {
        logic port;
        logic up;
        logic dn;
        logic lf;
        logic rt;
        logic tl;
        logic tr;
    } t_poll;

    // One result item as the block reports it.
    typedef struct packed {
        logic  port;
        t_word buttons;
        logic  conn;
        logic  next_sel;
    } t_pad_report;

    // Tracked decoder state of one port.
    typedef struct packed {
        logic              sel;
        logic              conn;
        logic              six;
        logic [SKIP_W-1:0] skip;
        t_word             word;
    } t_pad_track;

    // A directed row: the poll, and a typed-in result where one is given.
    typedef struct packed {
        t_poll       poll;
        logic        typed;
        t_pad_report want;
    } t_pad_row;

    // Poll columns: port _ up down left right _ tl tr.
    localparam t_pad_row DIRECTED [DIRECTED_ROWS] = '{
        '{7'b0_1111_11, 1'b1, '{1'b0, 13'h0000, 1'b0, 1'b1}},  // after reset, all released
        '{7'b0_0000_00, 1'b1, '{1'b0, 13'h003F, 1'b0, 1'b0}},  // no pad, all pressed
        '{7'b1_0000_00, 1'b1, '{1'b1, 13'h0000, 1'b1, 1'b1}},  // six-button detect
        '{7'b1_0000_00, 1'b0, '0},                             // six-button read
        '{7'b1_0111_11, 1'b0, '0},                             // first skipped poll, Home
        '{7'b0_1100_00, 1'b0, '0},                             // three-button detect, A, Start
        '{7'b1_1111_11, 1'b0, '0},                             // second skipped poll
        '{7'b0_1111_01, 1'b0, '0},                             // directions, B, C
        '{7'b1_1100_11, 1'b0, '0},                             // A and Start released
        '{7'b1_0101_10, 1'b0, '0},                             // mixed directions, C
        '{7'b0_0000_11, 1'b0, '0},                             // six-button detect keeps A
        '{7'b0_1111_00, 1'b0, '0},                             // six-button read, released
        '{7'b0_1000_00, 1'b0, '0},                             // skipped poll, Home released
        '{7'b0_0000_00, 1'b0, '0},                             // skipped poll ignores pins
        '{7'b1_1011_00, 1'b0, '0},                             // pad lost
        '{7'b1_1111_01, 1'b0, '0},                             // no pad, A from tl
        '{7'b0_1111_11, 1'b0, '0},                             // pad lost, all released
        '{7'b0_1111_11, 1'b0, '0},                             // no pad, word cleared
        '{7'b1_1101_10, 1'b0, '0},                             // left alone is no pad
        '{7'b1_1110_10, 1'b0, '0}                              // no pad, B from tr
    };

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_valid           = 1'b0;
    logic        i_port            = 1'b0;
    logic        i_pin_up_level    = 1'b1;
    logic        i_pin_down_level  = 1'b1;
    logic        i_pin_left_level  = 1'b1;
    logic        i_pin_right_level = 1'b1;
    logic        i_pin_tl_level    = 1'b1;
    logic        i_pin_tr_level    = 1'b1;
    logic        i_stall           = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_port_out;
    t_word       o_buttons;
    logic        o_pad_connected;
    logic        o_next_select;

    t_pad_track  pad_track [NUM_PORTS];
    t_pad_report reports_due [$];
    int          error_count  = 0;
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    bit          hold_wanted  = 1'b0;
    bit          hold_done    = 1'b0;
    int          hold_left    = 0;

    six_button_pad_reader #(.NUM_PORTS(NUM_PORTS)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_port            (i_port),
        .i_pin_up_level    (i_pin_up_level),
        .i_pin_down_level  (i_pin_down_level),
        .i_pin_left_level  (i_pin_left_level),
        .i_pin_right_level (i_pin_right_level),
        .i_pin_tl_level    (i_pin_tl_level),
        .i_pin_tr_level    (i_pin_tr_level),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_port_out        (o_port_out),
        .o_buttons         (o_buttons),
        .o_pad_connected   (o_pad_connected),
        .o_next_select     (o_next_select)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Decodes one poll against the tracked port state and returns the report.
    function automatic t_pad_report decode_poll(input t_poll s);
        t_pad_track  t;
        t_pad_report r;
        logic        up, dn, lf, rt, tl, tr;
        t  = pad_track[s.port];
        up = !s.up;
        dn = !s.dn;
        lf = !s.lf;
        rt = !s.rt;
        tl = !s.tl;
        tr = !s.tr;
        if (t.skip != '0) begin
            // Skipped poll: only the first one takes Home.
            if (t.skip == SKIP_POLLS) t.word[BIT_HOME] = up;
            t.skip = t.skip - 1'b1;
        end else if (t.sel) begin
            if (t.conn && t.six) begin
                t.word[BIT_Z]    = up;
                t.word[BIT_Y]    = dn;
                t.word[BIT_X]    = lf;
                t.word[BIT_MODE] = rt;
                t.six  = 1'b0;
                t.skip = SKIP_POLLS;
            end else begin
                // Without a pad the word is rebuilt with two fire buttons.
                if (!t.conn) t.word = '0;
                t.word[BIT_UP]    = up;
                t.word[BIT_DOWN]  = dn;
                t.word[BIT_LEFT]  = lf;
                t.word[BIT_RIGHT] = rt;
                if (t.conn) begin
                    t.word[BIT_B] = tl;
                    t.word[BIT_C] = tr;
                end else begin
                    t.word[BIT_A] = tl;
                    t.word[BIT_B] = tr;
                end
            end
        end else begin
            // Select low: pad and six-button detection, and A and Start on a three-button read.
            t.conn = lf && rt;
            t.six  = up && dn;
            if (t.conn && !t.six) begin
                t.word[BIT_A]     = tl;
                t.word[BIT_START] = tr;
            end
        end
        t.sel = !t.sel;
        pad_track[s.port] = t;
        r.port     = s.port;
        r.buttons  = t.word;
        r.conn     = t.conn;
        r.next_sel = t.sel;
        return r;
    endfunction

    // Random poll: mostly a pad answering at its select level, the rest noise.
    function automatic t_poll pick_poll();
        t_poll s;
        s = 7'($urandom_range(127));
        if ($urandom_range(99) < 75 && !pad_track[s.port].sel) begin
            s.lf = 1'b0;
            s.rt = 1'b0;
            if ($urandom_range(1) == 1) begin
                s.up = 1'b0;
                s.dn = 1'b0;
            end
        end
        return s;
    endfunction

    // Offers one poll until it is accepted, then records its expected report.
    task automatic offer_poll(input t_poll s, input logic typed, input t_pad_report typed_want);
        t_pad_report r;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_port, i_pin_up_level, i_pin_down_level, i_pin_left_level,
         i_pin_right_level, i_pin_tl_level, i_pin_tr_level} <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = decode_poll(s);
        reports_due.push_back(typed ? typed_want : r);
    endtask

    task automatic note_error(input string msg);
        if (error_count < MAX_REPORTS) $display("ERROR: %s", msg);
        error_count++;
    endtask

    // Compares one accepted result item with the oldest expected report.
    task automatic check_report();
        t_pad_report want;
        if (reports_due.size() == 0) begin
            note_error($sformatf("unexpected item: port %0d buttons %h connected %0d select %0d",
                                 o_port_out, o_buttons, o_pad_connected, o_next_select));
        end else begin
            want = reports_due.pop_front();
            if (o_port_out !== want.port || o_buttons !== want.buttons ||
                o_pad_connected !== want.conn || o_next_select !== want.next_sel) begin
                note_error($sformatf({"expected port %0d buttons %h connected %0d select %0d, ",
                                      "got port %0d buttons %h connected %0d select %0d"},
                                     want.port, want.buttons, want.conn, want.next_sel,
                                     o_port_out, o_buttons, o_pad_connected, o_next_select));
            end
        end
    endtask

    // Result side: check accepted items and drive the stall, with one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) check_report();
            if (hold_wanted && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any accepted item.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("** six_button_pad_reader: FAILED **");
        $finish;
    end

    // Main sequence: reset, directed rows, then random phases.
    initial begin : stimulus
        foreach (pad_track[i]) pad_track[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily.
        tx_idle_pct = 22;
        rx_idle_pct = 60;
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            offer_poll(DIRECTED[i].poll, DIRECTED[i].typed, DIRECTED[i].want);
        end
        repeat (400) offer_poll(pick_poll(), 1'b0, '0);

        // The other way round.
        tx_idle_pct = 60;
        rx_idle_pct = 22;
        repeat (400) offer_poll(pick_poll(), 1'b0, '0);

        // Sender pauses until every result has come back.
        i_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);

        // No idling; the receiver holds off while polls keep coming.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_wanted = 1'b1;
        repeat (40) offer_poll(pick_poll(), 1'b0, '0);
        repeat (390) offer_poll(pick_poll(), 1'b0, '0);

        // Drain and finish.
        i_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && reports_due.size() == 0) begin
            $display("** six_button_pad_reader: PASSED **");
        end else begin
            $display("** six_button_pad_reader: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sbpr_pkg.sv
rtl/core/sbpr_ram.sv
rtl/core/six_button_pad_reader.sv
sim/testbench.sv
